/* src/dip_pkg.sv */
`default_nettype none
package dip_pkg;

    localparam int EXP_BITS = 12;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_UNDEFINED = 2'd3;

    localparam logic [63:0] QNAN_BITS    = 64'h7FF8_0000_0000_0000;
    localparam logic [63:0] DEFNAN_BITS  = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] ONE_BITS     = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] QUIET_BIT    = 64'h0008_0000_0000_0000;

    // unbiased exponent, wide enough for sums and differences of two operands
    typedef logic signed [13:0] t_exp;

    typedef struct packed {
        logic [63:0]                base_bits;
        logic signed [EXP_BITS-1:0] exponent;
    } t_req;

    typedef struct packed {
        logic [63:0] power_bits;
        logic [1:0]  status;
    } t_res;

    typedef struct packed {
        logic load;
        logic init_acc;
        logic start_recip;
        logic start_step;
        logic take_result;
        logic write_out;
    } t_cmd;

    typedef struct packed {
        logic mag_zero;
        logic neg;
        logic steps_zero;
        logic fpu_done;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

/* src/double_integer_power.sv */
// Raises a binary64 base to a signed 12-bit integer power by repeated
// multiplication (positive power) or division (negative power) in one shared
// floating-point unit, each step rounded to nearest even with gradual
// underflow. One request is worked on at a time; the next is taken once the
// result sits in the output register. An operation with a zero, infinite or NaN
// operand needs no arithmetic, and a subnormal operand is first normalised one
// bit at a time. The unit holds a bit-serial divider and a four-pass 27x27
// multiplier. A power of zero needs no arithmetic. A stalled result holds the
// next result back from the output register, and with it the request after.
`default_nettype none
module double_integer_power
    import dip_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_req i_req,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_res      o_res
);

    t_cmd cmd;
    t_sts sts;

    dip_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    dip_dpath u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_stall (i_stall),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

endmodule
`default_nettype wire

/* src/dip_fpu.sv */
`default_nettype none
module dip_fpu
    import dip_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_div,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_done,
    output logic [63:0]      o_res
);

    typedef enum logic [2:0] {F_IDLE, F_NORM, F_MUL, F_DIV, F_RND} t_fstate;

    t_fstate      r_state;
    logic         r_done;
    logic [63:0]  r_res;
    logic         r_sign;
    logic         r_div;
    logic [52:0]  r_ma, r_mb;
    t_exp         r_ea, r_eb;
    logic [5:0]   r_cnt;
    logic [53:0]  r_pp;
    logic [1:0]   r_psh;
    logic [105:0] r_prod;
    logic [54:0]  r_rem;
    logic [55:0]  r_q;
    logic [55:0]  r_n;
    t_exp         r_e;
    logic         r_st;

    // operand classification and the cases that need no arithmetic
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn, special;
    logic [63:0] spec_res;

    always_comb begin
        a_nan  = (i_a[62:52] == 11'h7FF) && (i_a[51:0] != 52'd0);
        b_nan  = (i_b[62:52] == 11'h7FF) && (i_b[51:0] != 52'd0);
        a_inf  = (i_a[62:52] == 11'h7FF) && (i_a[51:0] == 52'd0);
        b_inf  = (i_b[62:52] == 11'h7FF) && (i_b[51:0] == 52'd0);
        a_zero = (i_a[62:0] == 63'd0);
        b_zero = (i_b[62:0] == 63'd0);
        sgn    = i_a[63] ^ i_b[63];
        special  = 1'b1;
        spec_res = {sgn, 63'd0};
        priority if (a_nan) begin
            spec_res = i_a | QUIET_BIT;
        end else if (b_nan) begin
            spec_res = i_b | QUIET_BIT;
        end else if (!i_div && ((a_inf && b_zero) || (a_zero && b_inf))) begin
            spec_res = DEFNAN_BITS;
        end else if (i_div && ((a_inf && b_inf) || (a_zero && b_zero))) begin
            spec_res = DEFNAN_BITS;
        end else if (a_inf || (!i_div && b_inf) || (i_div && b_zero)) begin
            spec_res = {sgn, 11'h7FF, 52'd0};
        end else if (a_zero || (!i_div && b_zero) || (i_div && b_inf)) begin
            spec_res = {sgn, 63'd0};
        end else begin
            special = 1'b0;
        end
    end

    // partial product selection: halves of 27 and 26 bits
    logic [26:0] mx, my;
    always_comb begin
        unique case (r_cnt[1:0])
            2'd0: begin
                mx = r_ma[26:0];         my = r_mb[26:0];
            end
            2'd1: begin
                mx = r_ma[26:0];         my = {1'b0, r_mb[52:27]};
            end
            2'd2: begin
                mx = {1'b0, r_ma[52:27]}; my = r_mb[26:0];
            end
            default: begin
                mx = {1'b0, r_ma[52:27]}; my = {1'b0, r_mb[52:27]};
            end
        endcase
    end

    logic [105:0] pp_shifted;
    always_comb begin
        unique case (r_psh)
            2'd0:    pp_shifted = {52'd0, r_pp};
            2'd1:    pp_shifted = {25'd0, r_pp, 27'd0};
            default: pp_shifted = {r_pp[51:0], 54'd0};
        endcase
    end

    // rounding to nearest even, with gradual underflow
    t_exp         be, sh_full, bexp;
    logic [5:0]   sh;
    logic [111:0] wide;
    logic [52:0]  m;
    logic         g, s, inc;
    logic [53:0]  rr;
    logic [51:0]  frac;
    logic [63:0]  rnd_res;

    always_comb begin
        be      = r_e + 14'sd1023;
        sh_full = 14'sd1 - be;
        sh      = (sh_full > 14'sd57) ? 6'd57 : sh_full[5:0];
        wide    = {r_n, 56'd0} >> sh;
        if (be > 14'sd0) begin
            m = r_n[55:3];
            g = r_n[2];
            s = (|r_n[1:0]) | r_st;
        end else begin
            m = wide[111:59];
            g = wide[58];
            s = (|wide[57:0]) | r_st;
        end
        inc = g & (s | m[0]);
        rr  = {1'b0, m} + {53'd0, inc};
        if (be > 14'sd0) begin
            bexp = be + {13'd0, rr[53]};
            frac = rr[53] ? 52'd0 : rr[51:0];
        end else begin
            bexp = {13'd0, rr[52]};
            frac = rr[51:0];
        end
        if (bexp >= 14'sd2047) begin
            rnd_res = {r_sign, 11'h7FF, 52'd0};
        end else begin
            rnd_res = {r_sign, bexp[10:0], frac};
        end
    end

    logic [54:0] rem_diff;
    assign rem_diff = r_rem - {2'b0, r_mb};

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (i_start) begin
                        r_sign <= sgn;
                        r_div  <= i_div;
                        if (special) begin
                            r_res  <= spec_res;
                            r_done <= 1'b1;
                        end else begin
                            r_ma    <= {i_a[62:52] != 11'd0, i_a[51:0]};
                            r_mb    <= {i_b[62:52] != 11'd0, i_b[51:0]};
                            r_ea    <= (i_a[62:52] == 11'd0) ? -14'sd1022
                                       : $signed({3'b0, i_a[62:52]}) - 14'sd1023;
                            r_eb    <= (i_b[62:52] == 11'd0) ? -14'sd1022
                                       : $signed({3'b0, i_b[62:52]}) - 14'sd1023;
                            r_state <= F_NORM;
                        end
                    end
                end
                F_NORM: begin
                    // subnormal operands: one bit a cycle until the lead bit is set
                    if (r_ma[52] && r_mb[52]) begin
                        r_cnt  <= 6'd0;
                        r_prod <= 106'd0;
                        r_rem  <= {2'b0, r_ma};
                        r_q    <= 56'd0;
                        r_state <= r_div ? F_DIV : F_MUL;
                    end else begin
                        if (!r_ma[52]) begin
                            r_ma <= {r_ma[51:0], 1'b0};
                            r_ea <= r_ea - 14'sd1;
                        end
                        if (!r_mb[52]) begin
                            r_mb <= {r_mb[51:0], 1'b0};
                            r_eb <= r_eb - 14'sd1;
                        end
                    end
                end
                F_MUL: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt < 6'd4) begin
                        r_pp  <= mx * my;
                        r_psh <= (r_cnt == 6'd0) ? 2'd0 : ((r_cnt == 6'd3) ? 2'd2 : 2'd1);
                    end
                    if (r_cnt >= 6'd1 && r_cnt <= 6'd4) begin
                        r_prod <= r_prod + pp_shifted;
                    end
                    if (r_cnt == 6'd5) begin
                        if (r_prod[105]) begin
                            r_n  <= r_prod[105:50];
                            r_st <= |r_prod[49:0];
                            r_e  <= r_ea + r_eb + 14'sd1;
                        end else begin
                            r_n  <= r_prod[104:49];
                            r_st <= |r_prod[48:0];
                            r_e  <= r_ea + r_eb;
                        end
                        r_state <= F_RND;
                    end
                end
                F_DIV: begin
                    // restoring division, one quotient bit a cycle
                    if (r_cnt == 6'd56) begin
                        r_n     <= r_q[55] ? r_q : {r_q[54:0], 1'b0};
                        r_e     <= r_q[55] ? (r_ea - r_eb) : (r_ea - r_eb - 14'sd1);
                        r_st    <= (r_rem != 55'd0);
                        r_state <= F_RND;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                        if (r_rem >= {2'b0, r_mb}) begin
                            r_q   <= {r_q[54:0], 1'b1};
                            r_rem <= {rem_diff[53:0], 1'b0};
                        end else begin
                            r_q   <= {r_q[54:0], 1'b0};
                            r_rem <= {r_rem[53:0], 1'b0};
                        end
                    end
                end
                default: begin
                    r_res   <= rnd_res;
                    r_done  <= 1'b1;
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule
`default_nettype wire

/* src/dip_dpath.sv */
`default_nettype none
module dip_dpath
    import dip_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_req i_req,
    input  wire logic i_stall,
    input  wire t_cmd i_cmd,
    output t_sts      o_sts,
    output logic      o_valid,
    output t_res      o_res
);

    logic [63:0]         r_base;
    logic [63:0]         r_acc;
    logic                r_neg;
    logic                r_mag_zero;
    logic                r_mag_ge2;
    logic [EXP_BITS-1:0] r_steps;
    logic                r_valid;
    t_res                r_res;

    logic [EXP_BITS-1:0] raw, mag;
    assign raw = i_req.exponent;
    assign mag = raw[EXP_BITS-1] ? (~raw + 1'b1) : raw;

    logic        fpu_start, fpu_done;
    logic [63:0] fpu_a, fpu_res;
    assign fpu_start = i_cmd.start_recip | i_cmd.start_step;
    assign fpu_a     = i_cmd.start_recip ? ONE_BITS : r_acc;

    dip_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (fpu_start),
        .i_div   (r_neg),
        .i_a     (fpu_a),
        .i_b     (r_base),
        .o_done  (fpu_done),
        .o_res   (fpu_res)
    );

    logic acc_inf, acc_zero;
    assign acc_inf  = (r_acc[62:0] == 63'h7FF0_0000_0000_0000);
    assign acc_zero = (r_acc[62:0] == 63'd0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_base     <= i_req.base_bits;
            r_neg      <= raw[EXP_BITS-1];
            r_mag_zero <= (mag == '0);
            r_mag_ge2  <= (mag > 1);
            r_steps    <= mag - 1'b1;
        end
        if (i_cmd.init_acc) begin
            r_acc <= r_base;
        end
        if (i_cmd.start_step) begin
            r_steps <= r_steps - 1'b1;
        end
        if (i_cmd.take_result) begin
            r_acc <= fpu_res;
        end
        if (i_cmd.write_out) begin
            if (r_mag_zero) begin
                if (r_base[62:0] == 63'd0) begin
                    r_res <= '{power_bits: QNAN_BITS, status: ST_UNDEFINED};
                end else begin
                    r_res <= '{power_bits: ONE_BITS, status: ST_OK};
                end
            end else begin
                r_res.power_bits <= r_acc;
                if (r_mag_ge2 && !r_neg && acc_inf) begin
                    r_res.status <= ST_OVERFLOW;
                end else if (r_mag_ge2 && r_neg && acc_zero) begin
                    r_res.status <= ST_UNDERFLOW;
                end else begin
                    r_res.status <= ST_OK;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.write_out) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_sts.mag_zero   = r_mag_zero;
    assign o_sts.neg        = r_neg;
    assign o_sts.steps_zero = (r_steps == '0);
    assign o_sts.fpu_done   = fpu_done;
    assign o_sts.out_free   = !r_valid || !i_stall;
    assign o_valid          = r_valid;
    assign o_res            = r_res;

endmodule
`default_nettype wire

/* src/dip_ctrl.sv */
`default_nettype none
module dip_ctrl
    import dip_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_sts i_sts,
    output logic      o_stall,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_LOOP, S_WAIT, S_FINISH} t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                priority if (i_sts.mag_zero) begin
                    n_state = S_FINISH;
                end else if (i_sts.neg) begin
                    o_cmd.start_recip = 1'b1;
                    n_state           = S_WAIT;
                end else begin
                    o_cmd.init_acc = 1'b1;
                    n_state        = S_LOOP;
                end
            end
            S_LOOP: begin
                if (i_sts.steps_zero) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.start_step = 1'b1;
                    n_state          = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_sts.fpu_done) begin
                    o_cmd.take_result = 1'b1;
                    n_state           = S_LOOP;
                end
            end
            default: begin
                if (i_sts.out_free) begin
                    o_cmd.write_out = 1'b1;
                    n_state         = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

/* tb/tb_double_integer_power.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_double_integer_power;
    import dip_pkg::*;

    localparam int  LIMIT_CYCLES = 20_000_000;
    localparam int  TAIL_CYCLES  = 200;
    localparam int  LONG_HOLD    = 400;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_req i_req;
    logic o_valid;
    logic i_stall;
    t_res o_res;

    t_res   pending_powers[$];
    int     fail_count;
    int     cycle_count;
    logic   hold_request;

    double_integer_power dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // binary64 power by repeated multiply or divide, rounded at every step
    function automatic t_res power_of(t_req r);
        real  x;
        real  acc;
        int   mag;
        logic neg;
        t_res res;
        x   = $bitstoreal(r.base_bits);
        neg = r.exponent[EXP_BITS-1];
        mag = neg ? -int'(r.exponent) : int'(r.exponent);
        res.status = ST_OK;
        if (mag == 0) begin
            if (x == 0.0) begin
                res.power_bits = QNAN_BITS;
                res.status     = ST_UNDEFINED;
            end else begin
                res.power_bits = ONE_BITS;
            end
            return res;
        end
        acc = neg ? 1.0 / x : x;
        for (int k = 1; k < mag; k++) begin
            if (neg)
                acc = acc / x;
            else
                acc = acc * x;
        end
        res.power_bits = $realtobits(acc);
        if (mag >= 2) begin
            if (!neg && (res.power_bits & 64'h7FFF_FFFF_FFFF_FFFF) == 64'h7FF0_0000_0000_0000)
                res.status = ST_OVERFLOW;
            else if (neg && acc == 0.0)
                res.status = ST_UNDERFLOW;
        end
        return res;
    endfunction

    task automatic send_request(input logic [63:0] base, input int power);
        int   gap;
        t_req r;
        r.base_bits = base;
        r.exponent  = power[EXP_BITS-1:0];
        gap = $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        pending_powers.push_back(power_of(r));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_powers.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] pick_base();
        logic [63:0] b;
        b = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1: ;
            2, 3, 4, 5: b[62:52] = 11'(1023 + $urandom_range(0, 6) - 3);
            6: b[62:52] = 11'd0;
            7: b[62:0] = 63'd0;
            8: b[62:52] = 11'h7FF;
            default: b[62:52] = $urandom_range(0, 1) ? 11'(1023 + $urandom_range(0, 80))
                                                     : 11'(1023 - $urandom_range(0, 80));
        endcase
        return b;
    endfunction

    function automatic int pick_power();
        if ($urandom_range(0, 19) == 0)
            return int'($urandom_range(0, 600)) - 300;
        return int'($urandom_range(0, 32)) - 16;
    endfunction

    task automatic test_directed();
        send_request(64'h0000_0000_0000_0000, 0);
        send_request(64'h8000_0000_0000_0000, 0);
        send_request(64'h7FF8_0000_0000_0001, 0);
        send_request(64'h4000_0000_0000_0000, 1);
        send_request(64'h0000_0000_0000_0000, -1);
        send_request(64'h8000_0000_0000_0000, -1);
        send_request(64'h7FF0_0000_0000_0000, 1);
        send_request(64'h7FF0_0000_0000_0000, 2);
        send_request(64'hFFF0_0000_0000_0000, 3);
        send_request(64'h0000_0000_0000_0000, 3);
        send_request(64'h8000_0000_0000_0000, -2);
        send_request(64'h7E37_E43C_8800_759C, 2);   // 1e300 squared
        send_request(64'h7E37_E43C_8800_759C, -2);
        send_request(64'h0000_0000_0000_0001, 2);
        send_request(64'h0000_0000_0000_0001, -1);
        send_request(64'h000F_FFFF_FFFF_FFFF, -3);
        send_request(64'hFFF8_0000_0000_0000, 5);
        send_request(64'h7FF4_0000_0000_0000, -4);
        send_request(64'hBFF0_0000_0000_0001, 2047);
        send_request(64'h3FF0_0000_0000_0001, -2048);
        send_request(64'hC000_0000_0000_0000, -7);
        send_request(64'hFFFF_FFFF_FFFF_FFFF, 1);
        send_request(64'h7FEF_FFFF_FFFF_FFFF, -1);
    endtask

    task automatic test_random(input int count);
        for (int k = 0; k < count; k++)
            send_request(pick_base(), pick_power());
    endtask

    task automatic test_backpressure();
        hold_request <= 1'b1;
        for (int k = 0; k < 8; k++)
            send_request(pick_base(), int'($urandom_range(0, 8)) - 4);
    endtask

    task automatic test_pause_until_drained();
        wait_drained();
        test_random(10);
    endtask

    // receiver side: random stall before each result, one long stretch on request
    initial begin
        int gap;
        i_stall <= 1'b0;
        forever begin
            if (hold_request) begin
                gap = LONG_HOLD;
                hold_request <= 1'b0;
            end else begin
                gap = $urandom_range(0, 9);
            end
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_powers.size() == 0) begin
                $error("unexpected request result: power_bits %h status %0d",
                       o_res.power_bits, o_res.status);
                fail_count++;
            end else begin
                if (o_res.power_bits !== pending_powers[0].power_bits) begin
                    $error("power_bits expected %h actual %h",
                           pending_powers[0].power_bits, o_res.power_bits);
                    fail_count++;
                end
                if (o_res.status !== pending_powers[0].status) begin
                    $error("status expected %0d actual %0d",
                           pending_powers[0].status, o_res.status);
                    fail_count++;
                end
                void'(pending_powers.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        fail_count   = 0;
        cycle_count  = 0;
        hold_request = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_req   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(60);
        test_backpressure();
        test_pause_until_drained();
        test_random(39);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_powers.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
